/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the top-level design file. Simulation gets the checks;
// synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is high.
`define SGD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SGD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SGD_ASSERT(label, clk, rst, prop, msg)
`define SGD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* design/sgd_pkg.sv */
// ----------------------------------------------------------------------------
// sgd_pkg
// Types, constants and a helper function for the safegcd divstep batch block.
// ----------------------------------------------------------------------------
package sgd_pkg;

   // Internal eta width: wide enough that a batch never overflows it.
   localparam int ETA_W = 18;

   // Negated inverses of odd residues modulo 16, indexed by bits 3:1.
   localparam logic [3:0] NEG_INV_TAB [0:7] = '{
      4'd15, 4'd5, 4'd3, 4'd9, 4'd7, 4'd13, 4'd11, 4'd1
   };

   typedef struct packed {
      logic signed [15:0] eta_in;
      logic signed [63:0] f_low;
      logic signed [63:0] g_low;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] eta_out;
      logic signed [63:0] mat_u;
      logic signed [63:0] mat_v;
      logic signed [63:0] mat_q;
      logic signed [63:0] mat_r;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic done;
   } dp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } ctrl_state_type;

   // Multiplies a word by a 4-bit factor modulo 2^64 with shifted adds.
   function automatic logic [63:0] mul_nib(input logic [63:0] x, input logic [3:0] w);
      logic [63:0] acc;
      acc = 64'd0;
      if (w[0]) acc = acc + x;
      if (w[1]) acc = acc + {x[62:0], 1'b0};
      if (w[2]) acc = acc + {x[61:0], 2'b0};
      if (w[3]) acc = acc + {x[60:0], 3'b0};
      return acc;
   endfunction

endpackage

/* design/sgd_ctrl.sv */
// ----------------------------------------------------------------------------
// sgd_ctrl
// Sequencer for the divstep batch: loads a request, steps the datapath until
// the step budget is spent, then hands the result to the output register.
// ----------------------------------------------------------------------------
module sgd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sgd_pkg::dp_status_type status,
   output sgd_pkg::ctrl_cmd_type  cmd
);
   import sgd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.done) begin
               if (out_free) begin
                  cmd.publish  = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/sgd_datapath.sv */
// ----------------------------------------------------------------------------
// sgd_datapath
// Working registers for f, g, eta and the transition matrix. Each step either
// shifts one trailing zero out of g or does an optional swap and a reduction
// that clears up to four low bits of g. Also holds the output register.
// ----------------------------------------------------------------------------
module sgd_datapath #(
   parameter int BATCH_STEPS = 62
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sgd_pkg::ctrl_cmd_type   cmd,
   output sgd_pkg::dp_status_type  status,
   input  sgd_pkg::req_payload_type req_data,
   output sgd_pkg::rsp_payload_type rsp_data
);
   import sgd_pkg::*;

   localparam int LW = $clog2(BATCH_STEPS + 1);

   logic signed [ETA_W-1:0] eta_ff, eta_in;
   logic [63:0]             f_ff, f_in, g_ff, g_in;
   logic [63:0]             u_ff, u_in, v_ff, v_in, q_ff, q_in, r_ff, r_in;
   logic [LW-1:0]           left_ff, left_in;
   rsp_payload_type         out_ff, out_in;

   // Reduction round operands after the optional swap.
   logic                    swap;
   logic signed [ETA_W-1:0] eta_s;
   logic [63:0]             f_s, g_s, u_s, v_s, q_s, r_s;
   logic [2:0]              lim;
   logic [3:0]              mask;
   logic [3:0]              wprod;
   logic [3:0]              w;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      eta_ff <= eta_in;
      f_ff   <= f_in;
      g_ff   <= g_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      out_ff <= out_in;
   end

   always_comb begin
      swap  = eta_ff[ETA_W-1];
      eta_s = swap ? -eta_ff : eta_ff;
      f_s   = swap ? g_ff : f_ff;
      g_s   = swap ? (64'd0 - f_ff) : g_ff;
      u_s   = swap ? q_ff : u_ff;
      v_s   = swap ? r_ff : v_ff;
      q_s   = swap ? (64'd0 - u_ff) : q_ff;
      r_s   = swap ? (64'd0 - v_ff) : r_ff;

      // Bits cleared this round: min(eta + 1, steps left, 4).
      lim = 3'd4;
      if (left_ff < LW'(4)) lim = left_ff[2:0];
      if ((eta_s < ETA_W'(3)) && ((eta_s[2:0] + 3'd1) < lim)) lim = eta_s[2:0] + 3'd1;
      mask  = 4'((5'd1 << lim) - 5'd1);
      wprod = 4'(g_s[3:0] * NEG_INV_TAB[f_s[3:1]]);
      w     = wprod & mask;
   end

   always_comb begin
      eta_in  = eta_ff;
      f_in    = f_ff;
      g_in    = g_ff;
      u_in    = u_ff;
      v_in    = v_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      left_in = left_ff;
      out_in  = out_ff;
      if (cmd.load) begin
         eta_in  = {{(ETA_W-16){req_data.eta_in[15]}}, req_data.eta_in};
         f_in    = req_data.f_low | 64'd1;
         g_in    = req_data.g_low;
         u_in    = 64'd1;
         v_in    = 64'd0;
         q_in    = 64'd0;
         r_in    = 64'd1;
         left_in = LW'(BATCH_STEPS);
      end else if (cmd.step) begin
         if (!g_ff[0]) begin
            // One trailing zero: arithmetic shift of g, u and v double.
            eta_in  = eta_ff - ETA_W'(1);
            g_in    = {g_ff[63], g_ff[63:1]};
            u_in    = {u_ff[62:0], 1'b0};
            v_in    = {v_ff[62:0], 1'b0};
            left_in = left_ff - LW'(1);
         end else begin
            eta_in = eta_s;
            f_in   = f_s;
            u_in   = u_s;
            v_in   = v_s;
            g_in   = g_s + mul_nib(f_s, w);
            q_in   = q_s + mul_nib(u_s, w);
            r_in   = r_s + mul_nib(v_s, w);
         end
      end
      if (cmd.publish) begin
         out_in.eta_out = eta_ff[15:0];
         out_in.mat_u   = u_ff;
         out_in.mat_v   = v_ff;
         out_in.mat_q   = q_ff;
         out_in.mat_r   = r_ff;
      end
   end

   assign status.done = (left_ff == '0);
   assign rsp_data    = out_ff;

endmodule

/* design/safegcd_divsteps_batch_matrix_top.sv */
// The request is loaded, then one round runs per cycle (a single-bit shift of g,
// or an optional swap and an up-to-4-bit reduction), at most 2*BATCH_STEPS
// rounds, then the result is written into the output register once it is free.
// One shared datapath works one request at a time; the next request is taken
// as soon as the result sits in the output register.
// Synchronous reset clears the sequencer, the step counter and the result valid flag.
// ----------------------------------------------------------------------------
// safegcd_divsteps_batch_matrix_top
// Batched safegcd divsteps on the low words of f and g, returning the new eta
// and the 2x2 transition matrix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module safegcd_divsteps_batch_matrix_top #(
   parameter int BATCH_STEPS = 62
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sgd_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sgd_pkg::rsp_payload_type rsp_data
);
   import sgd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sgd_datapath #(
      .BATCH_STEPS (BATCH_STEPS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // A result is never written over one that has not been taken.
   `SGD_ASSERT(a_no_overwrite, clock, reset, cmd.publish |-> (!rsp_valid || rsp_ready), "result overwritten before it was taken")

   // A freshly loaded request always has steps left to run.
   `SGD_ASSERT(a_load_not_done, clock, reset, cmd.load |=> !status.done, "step budget empty right after load")

   // Once a request is taken, no other is taken until it has been published.
   `SGD_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "request accepted while busy")

   // The datapath never gets more than one of load, step and publish in the same cycle.
   `SGD_ASSERT_ALWAYS(a_cmd_exclusive, clock, $onehot0({cmd.load, cmd.step, cmd.publish}), "conflicting datapath commands")

endmodule
